FILE: design/fcc_pkg.sv
// ---------------------------------------------------------------------------
// fcc_pkg: frame CRC-8 / CRC-16 checksum package
// Byte-wide CRC fold functions and the constants of both frame formats.
// ---------------------------------------------------------------------------
package fcc_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CrcW  = 16;

    localparam logic [CrcW-1:0]  Crc16Init   = 16'hFFFF;
    localparam logic [CrcW-1:0]  Crc16Poly   = 16'h1021;
    localparam logic [ByteW-1:0] Crc8Init    = 8'hFF;
    // 0x31 bit-reversed for the right-shifting form
    localparam logic [ByteW-1:0] Crc8PolyRef = 8'h8C;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [CrcW-1:0]  crc_t;

    typedef struct packed {
        crc_t checksum_value;
        logic remainder_zero;
    } result_t;

    // MSB-first CRC-16, one byte folded in
    function automatic crc_t fold_crc16(input crc_t crc, input byte_t data);
        crc_t c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < ByteW; i++)
        begin
            if (c[CrcW-1])
                c = {c[CrcW-2:0], 1'b0} ^ Crc16Poly;
            else
                c = {c[CrcW-2:0], 1'b0};
        end
        return c;
    endfunction

    // Reflected CRC-8, one byte folded in
    function automatic byte_t fold_crc8(input byte_t crc, input byte_t data);
        byte_t c;
        c = crc ^ data;
        for (int i = 0; i < ByteW; i++)
        begin
            if (c[0])
                c = {1'b0, c[ByteW-1:1]} ^ Crc8PolyRef;
            else
                c = {1'b0, c[ByteW-1:1]};
        end
        return c;
    endfunction

endpackage

FILE: design/frame_crc8_crc16_checksum.sv
// ---------------------------------------------------------------------------
// frame_crc8_crc16_checksum
// Byte-serial frame checker: reflected CRC-8 (poly 0x31) for short frames,
// MSB-first CRC-16 (poly 0x1021) for long frames, result on the last byte.
// ---------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  in      | in_valid / in_stall       | frame_byte, first_byte, last_byte,
//          |                           | long_format
//  out     | out_valid / out_stall     | checksum_value, remainder_zero
//
//  One byte per cycle unless in_stall; the CRC fold is one XOR network
//  between the CRC register and the two-entry result buffer (output
//  register plus skid), which absorbs output stalls; in_stall rises only
//  when the skid entry is full.
//  Reset: CRC register 0xFFFF, short format, both result entries empty.
// ---------------------------------------------------------------------------
module frame_crc8_crc16_checksum
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fcc_pkg::byte_t       frame_byte,
    input  logic                 first_byte,
    input  logic                 last_byte,
    input  logic                 long_format,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fcc_pkg::crc_t        checksum_value,
    output logic                 remainder_zero
);
    import fcc_pkg::*;

    crc_t    crc_reg,  crc_next;
    logic    fmt_reg,  fmt_next;
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg,  out_next;
    result_t skid_reg, skid_next;

    logic    in_acc;
    logic    out_pop;
    logic    push;
    crc_t    base_crc;
    crc_t    new_crc;
    crc_t    value;
    result_t new_res;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid & ~in_stall;
    assign out_pop  = out_valid_reg & ~out_stall;
    assign push     = in_acc & last_byte;

    always_comb
    begin
        fmt_next = first_byte ? long_format : fmt_reg;
        if (first_byte)
            base_crc = long_format ? Crc16Init : {8'h00, Crc8Init};
        else
            base_crc = crc_reg;
        if (fmt_next)
            new_crc = fold_crc16(base_crc, frame_byte);
        else
            new_crc = {8'h00, fold_crc8(base_crc[ByteW-1:0], frame_byte)};
        crc_next = new_crc;
        value    = new_crc;
        new_res.checksum_value = value;
        new_res.remainder_zero = (value == '0);
    end

    // result buffer: output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !out_pop)
        begin
            if (push)
            begin
                skid_valid_next = 1'b1;
                skid_next       = new_res;
            end
        end
        else if (skid_valid_reg)
        begin
            // advance skid; no request enters while skid is full
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = push;
            if (push)
                out_next = new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= Crc16Init;
            fmt_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                crc_reg <= crc_next;
                fmt_reg <= fmt_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign checksum_value = out_reg.checksum_value;
    assign remainder_zero = out_reg.remainder_zero;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.remainder_zero == (out_reg.checksum_value == '0)))
        else $error("remainder_zero disagrees with checksum_value");

    a_short_high_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(in_acc) && !fmt_reg) |-> (crc_reg[CrcW-1:ByteW] == '0))
        else $error("short format CRC has high byte set");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_valid_reg ##1 skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled without a stalled output");
`endif

endmodule
